FILE: design/fsq_pkg.sv
package fsq_pkg;

    localparam int DATA_W  = 16;
    localparam int Q_SHIFT = 15;
    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_COEF   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef logic signed [DATA_W-1:0] t_sample;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

FILE: design/fsq_ram.sv
module fsq_ram
    import fsq_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clr,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_sample           i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_sample           o_rdata
);

    t_sample            r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    t_sample            r_rdata;
    logic               r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= r_vld[i_raddr];
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

FILE: design/fsq_mac.sv
module fsq_mac
    import fsq_pkg::*;
#(
    parameter int TAP_COUNT = 16,
    parameter int ACC_W     = 2 * DATA_W + $clog2(TAP_COUNT)
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mac_ctl i_ctl,
    input  t_sample  i_dly,
    input  t_sample  i_coef,
    output logic     o_done,
    output t_sample  o_result
);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

    t_mac_ctl                   r_ctl1;
    t_mac_ctl                   r_ctl2;
    logic                       r_done;
    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    n_acc;
    logic signed [ACC_W-1:0]    shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_done <= r_ctl2.vld & r_ctl2.last;
        end
    end

    always_comb begin
        if (r_ctl2.first) begin
            n_acc = ACC_W'(r_prod);
        end else begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_dly * i_coef;
        if (r_ctl2.vld) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        shifted = r_acc >>> Q_SHIFT;
        if (shifted > SAT_HI) begin
            o_result = t_sample'(OUT_MAX);
        end else if (shifted < SAT_LO) begin
            o_result = t_sample'(OUT_MIN);
        end else begin
            o_result = shifted[DATA_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

FILE: design/fir_q15_saturating_unit.sv
// 16-tap direct-form FIR on signed 16-bit samples with Q15 coefficients (TAP_COUNT taps,
// 2 to 16). The delay line is a circular buffer in one memory and the coefficients sit in
// a second memory; both read as zero after reset, and a clear item zeroes the delay line
// at once. A sample item holds the input from its transfer to the next input transfer:
// one read of each memory and one multiply-accumulate per tap, the read, product and
// accumulator registers, then the output register load, which waits while the previous
// result is stalled. The result is floor(sum / 2^15) saturated to 16 bits. Coefficient
// writes and clears do not hold the input and give no result. A finished result waits in
// the output register while the next item is accepted. Coefficient writes with tap_index
// of TAP_COUNT or more and items of kind 3 are dropped.
module fir_q15_saturating_unit
    import fsq_pkg::*;
#(
    parameter int TAP_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  t_sample     i_sample_in,
    input  logic [3:0]  i_tap_index,
    input  t_sample     i_tap_value,
    output logic        o_valid,
    input  logic        i_stall,
    output t_sample     o_filtered
);

    localparam int ADDR_W = $clog2(TAP_COUNT);
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TAP_COUNT - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [ADDR_W-1:0] r_head;
    logic [ADDR_W-1:0] n_head;
    logic [ADDR_W-1:0] r_rptr;
    logic [ADDR_W-1:0] r_cnt;
    logic              r_out_vld;
    t_sample           r_out_data;

    logic              accept;
    logic              dly_we;
    logic              dly_clr;
    logic              coef_we;
    logic              load;
    t_mac_ctl          mac_ctl;
    t_sample           dly_q;
    t_sample           coef_q;
    logic              mac_done;
    t_sample           mac_result;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid & ~o_stall;
    assign n_head  = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign dly_we  = accept & (i_kind == KIND_SAMPLE);
    assign dly_clr = accept & (i_kind == KIND_CLEAR);
    assign coef_we = accept & (i_kind == KIND_COEF) & (32'(i_tap_index) < TAP_COUNT);
    assign load    = (r_state == S_OUT) & (~r_out_vld | ~i_stall);

    always_comb begin
        mac_ctl.vld   = (r_state == S_READ);
        mac_ctl.first = (r_cnt == '0);
        mac_ctl.last  = (r_cnt == LAST);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (dly_we) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_cnt == LAST) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (mac_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_rptr    <= '0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (dly_we) begin
                r_head <= n_head;
                r_rptr <= n_head;
                r_cnt  <= '0;
            end else if (r_state == S_READ) begin
                r_rptr <= (r_rptr == '0) ? LAST : r_rptr - 1'b1;
                r_cnt  <= r_cnt + 1'b1;
            end
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (~i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= mac_result;
        end
    end

    fsq_ram #(
        .DEPTH (TAP_COUNT)
    ) u_dly_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (dly_clr),
        .i_we    (dly_we),
        .i_waddr (n_head),
        .i_wdata (i_sample_in),
        .i_raddr (r_rptr),
        .o_rdata (dly_q)
    );

    fsq_ram #(
        .DEPTH (TAP_COUNT)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (1'b0),
        .i_we    (coef_we),
        .i_waddr (ADDR_W'(i_tap_index)),
        .i_wdata (i_tap_value),
        .i_raddr (r_cnt),
        .o_rdata (coef_q)
    );

    fsq_mac #(
        .TAP_COUNT (TAP_COUNT)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_dly    (dly_q),
        .i_coef   (coef_q),
        .o_done   (mac_done),
        .o_result (mac_result)
    );

    assign o_valid    = r_out_vld;
    assign o_filtered = r_out_data;

endmodule

FILE: design/fsq_checker.sv
module fsq_checker
    import fsq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_kind,
    input logic        o_valid,
    input logic        i_stall,
    input t_sample     o_filtered
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_filtered)))
        else $error("result changed while stalled");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_kind == KIND_SAMPLE) |=> o_stall)
        else $error("sample transfer did not start filtering");

    a_other_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_kind != KIND_SAMPLE) |=> !o_stall)
        else $error("non-sample transfer held the input");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a sample in flight");

endmodule

bind fir_q15_saturating_unit fsq_checker u_fsq_checker (.*);
